// File: design/psev_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psev_pkg
// Types, codes and helpers shared by the postfix stack evaluator.
// ----------------------------------------------------------------------------
package psev_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int DATA_W      = 32;
   localparam int OP_W        = 4;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 2;

   // token codes
   localparam logic [OP_W-1:0] OP_PUSH   = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 4'd1;
   localparam logic [OP_W-1:0] OP_SUB    = 4'd2;
   localparam logic [OP_W-1:0] OP_MUL    = 4'd3;
   localparam logic [OP_W-1:0] OP_DIV    = 4'd4;
   localparam logic [OP_W-1:0] OP_NEG    = 4'd5;
   localparam logic [OP_W-1:0] OP_IF     = 4'd6;
   localparam logic [OP_W-1:0] OP_MIN    = 4'd7;
   localparam logic [OP_W-1:0] OP_MAX    = 4'd8;
   localparam logic [OP_W-1:0] OP_FINISH = 4'd9;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [DATA_W-1:0]  number;
      logic [COUNT_W-1:0]        fold_count;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  top_value;
      logic [COUNT_W-1:0]        entry_count;
      logic [STATUS_W-1:0]       status;
      logic                      finished;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIV,
      S_WRITE,
      S_RESP
   } psev_state_type;

   // entries popped by a token; zero for tokens that pop nothing
   function automatic logic [COUNT_W-1:0] pop_count(input logic [OP_W-1:0] op,
                                                    input logic [COUNT_W-1:0] cnt);
      logic [COUNT_W-1:0] n;
      n = '0;
      unique case (op)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: n = COUNT_W'(2);
         OP_NEG:                         n = COUNT_W'(1);
         OP_IF:                          n = COUNT_W'(3);
         OP_MIN, OP_MAX:                 n = (cnt == '0) ? COUNT_W'(1) : cnt;
         default:                        n = '0;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

// File: design/psev_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psev_divider
// Signed 32-bit divider, restoring, one quotient bit per cycle. Truncates
// toward zero; the divisor is never zero when started.
// ----------------------------------------------------------------------------
module psev_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [psev_pkg::DATA_W-1:0]    dividend,
   input  wire logic [psev_pkg::DATA_W-1:0]    divisor,
   output logic                                done,
   output logic [psev_pkg::DATA_W-1:0]         quotient
);

   localparam int W  = psev_pkg::DATA_W;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  md_ff, md_in;
   logic          neg_ff, neg_in;
   logic [W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      md_in   = md_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[W-1]} - {1'b0, md_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[W-1] ? (W'(0) - dividend) : dividend;
         md_in   = divisor[W-1] ? (W'(0) - divisor) : divisor;
         neg_in  = dividend[W-1] ^ divisor[W-1];
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      md_ff  <= md_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (W'(0) - quo_ff) : quo_ff;

endmodule
`default_nettype wire

// File: design/postfix_stack_evaluator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Evaluates decoded postfix tokens on a stack of 32-bit signed integers kept
// in a synchronous memory, with the top entry cached in a register.
// ----------------------------------------------------------------------------
//  channel | dir | payload             | handshake
//  req_    | in  | psev_pkg::req_type  | req_valid / req_stall (driven here)
//  rsp_    | out | psev_pkg::rsp_type  | rsp_valid / rsp_stall (from sink)
//
// Push, finish, unknown and ignored tokens go straight to the result stage.
// Tokens that pop n entries (2 arith, 1 negate, 3 if, fold count for min/max)
// pass read, execute and write, with one memory read per popped entry; divide
// also runs the bit-serial divider, and divide by zero skips it and the write.
// One request in flight; the result register lets the next request in while
// a result is stalled. Reset is synchronous and empties the stack.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
   parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire psev_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output psev_pkg::rsp_type       rsp_data
);

   localparam int W   = psev_pkg::DATA_W;
   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int KW  = (SPW > 8) ? SPW : 8;
   localparam int NW  = psev_pkg::COUNT_W;

   psev_pkg::psev_state_type state_ff, state_in;

   logic [SPW-1:0]              sp_ff, sp_in;
   logic [W-1:0]                top_ff, top_in;
   logic                        err_ff, err_in;
   logic [psev_pkg::OP_W-1:0]   op_ff, op_in;
   logic [W-1:0]                x_ff, x_in;
   logic [W-1:0]                y_ff, y_in;
   logic [W-1:0]                c_ff, c_in;
   logic [W-1:0]                acc_ff, acc_in;
   logic [W-1:0]                newtop_ff, newtop_in;
   logic [W-1:0]                res_ff, res_in;
   logic [NW-1:0]               npop_ff, npop_in;
   logic [SPW-1:0]              sp_pop_ff, sp_pop_in;
   logic [7:0]                  iss_k_ff, iss_k_in;
   logic [7:0]                  rd_k_ff, rd_k_in;
   logic                        rd_live_ff, rd_live_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic [psev_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                        fin_ff, fin_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   psev_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // stack memory
   logic [W-1:0]  mem [STACK_DEPTH];
   logic [W-1:0]  mem_q_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [W-1:0]  mem_wdata;

   logic          div_start, div_done;
   logic [W-1:0]  div_quot;

   logic [NW-1:0] npop_req;
   logic [KW-1:0] npop_w, sp_w, rd_addr_w;
   logic [W-1:0]  rd_val;
   logic          iss_live;

   psev_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (y_ff),
      .divisor  (x_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      top_in       = top_ff;
      err_in       = err_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      c_in         = c_ff;
      acc_in       = acc_ff;
      newtop_in    = newtop_ff;
      res_in       = res_ff;
      npop_in      = npop_ff;
      sp_pop_in    = sp_pop_ff;
      iss_k_in     = iss_k_ff;
      rd_k_in      = rd_k_ff;
      rd_live_in   = rd_live_ff;
      rd_pend_in   = rd_pend_ff;
      status_in    = status_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;
      mem_wdata    = '0;
      div_start    = 1'b0;

      npop_req  = psev_pkg::pop_count(req_data.op, req_data.fold_count);
      npop_w    = KW'(npop_req);
      sp_w      = KW'(sp_ff);
      // entry k below the top sits at sp - 1 - k
      rd_addr_w = sp_w - KW'(1) - KW'(iss_k_ff);
      iss_live  = KW'(iss_k_ff) < sp_w;
      rd_val    = rd_live_ff ? mem_q_ff : '0;

      unique case (state_ff)
         psev_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.op;
               x_in      = top_ff;
               acc_in    = top_ff;
               fin_in    = 1'b0;
               status_in = psev_pkg::ST_OK;
               npop_in   = npop_req;
               sp_pop_in = (npop_w >= sp_w) ? '0 : SPW'(sp_w - npop_w);
               iss_k_in  = 8'd1;
               rd_pend_in = 1'b0;
               priority if (req_data.op == psev_pkg::OP_FINISH) begin
                  fin_in    = 1'b1;
                  status_in = err_ff ? psev_pkg::ST_DIV_ZERO : psev_pkg::ST_OK;
                  state_in  = psev_pkg::S_RESP;
               end else if (err_ff) begin
                  status_in = psev_pkg::ST_IGNORED;
                  state_in  = psev_pkg::S_RESP;
               end else if (req_data.op == psev_pkg::OP_PUSH) begin
                  if (sp_ff == SPW'(STACK_DEPTH)) begin
                     status_in = psev_pkg::ST_OVERFLOW;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(sp_ff);
                     mem_wdata = req_data.number;
                     sp_in     = sp_ff + SPW'(1);
                     top_in    = req_data.number;
                  end
                  state_in = psev_pkg::S_RESP;
               end else if (npop_req != '0) begin
                  state_in = psev_pkg::S_READ;
               end else begin
                  state_in = psev_pkg::S_RESP;
               end
            end
         end

         psev_pkg::S_READ: begin
            // one read issued per cycle; the last one fetches the new top
            if (iss_k_ff <= 8'(npop_ff)) begin
               mem_re     = iss_live;
               mem_raddr  = AW'(rd_addr_w);
               rd_k_in    = iss_k_ff;
               rd_live_in = iss_live;
               rd_pend_in = 1'b1;
               iss_k_in   = iss_k_ff + 8'd1;
            end else begin
               rd_pend_in = 1'b0;
            end
            if (rd_pend_ff) begin
               if (rd_k_ff == 8'(npop_ff)) begin
                  newtop_in  = rd_val;
                  rd_pend_in = 1'b0;
                  state_in   = psev_pkg::S_EXEC;
               end else begin
                  if (rd_k_ff == 8'd1) y_in = rd_val;
                  if (rd_k_ff == 8'd2) c_in = rd_val;
                  if (op_ff == psev_pkg::OP_MIN) begin
                     if ($signed(rd_val) < $signed(acc_ff)) acc_in = rd_val;
                  end else if (op_ff == psev_pkg::OP_MAX) begin
                     if ($signed(acc_ff) < $signed(rd_val)) acc_in = rd_val;
                  end
               end
            end
         end

         psev_pkg::S_EXEC: begin
            state_in = psev_pkg::S_WRITE;
            unique case (op_ff)
               psev_pkg::OP_ADD: res_in = y_ff + x_ff;
               psev_pkg::OP_SUB: res_in = y_ff - x_ff;
               psev_pkg::OP_MUL: res_in = W'(y_ff * x_ff);
               psev_pkg::OP_NEG: res_in = W'(0) - x_ff;
               psev_pkg::OP_IF:  res_in = ($signed(c_ff) > 0) ? y_ff : x_ff;
               psev_pkg::OP_MIN,
               psev_pkg::OP_MAX: res_in = acc_ff;
               psev_pkg::OP_DIV: begin
                  if (x_ff == '0) begin
                     sp_in     = sp_pop_ff;
                     top_in    = newtop_ff;
                     err_in    = 1'b1;
                     status_in = psev_pkg::ST_DIV_ZERO;
                     state_in  = psev_pkg::S_RESP;
                  end else begin
                     div_start = 1'b1;
                     state_in  = psev_pkg::S_DIV;
                  end
               end
               default: state_in = psev_pkg::S_RESP;
            endcase
         end

         psev_pkg::S_DIV: begin
            if (div_done) begin
               res_in   = div_quot;
               state_in = psev_pkg::S_WRITE;
            end
         end

         psev_pkg::S_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(sp_pop_ff);
            mem_wdata = res_ff;
            sp_in     = sp_pop_ff + SPW'(1);
            top_in    = res_ff;
            state_in  = psev_pkg::S_RESP;
         end

         psev_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.finished    = fin_ff;
               if (fin_ff) begin
                  rsp_data_in.top_value   = err_ff ? '0 : top_ff;
                  rsp_data_in.entry_count = '0;
                  sp_in  = '0;
                  top_in = '0;
                  err_in = 1'b0;
               end else begin
                  rsp_data_in.top_value   = top_ff;
                  rsp_data_in.entry_count = NW'(sp_ff);
               end
               state_in = psev_pkg::S_IDLE;
            end
         end

         default: state_in = psev_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psev_pkg::S_IDLE;
         sp_ff        <= '0;
         top_ff       <= '0;
         err_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         top_ff       <= top_in;
         err_ff       <= err_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      c_ff        <= c_in;
      acc_ff      <= acc_in;
      newtop_ff   <= newtop_in;
      res_ff      <= res_in;
      npop_ff     <= npop_in;
      sp_pop_ff   <= sp_pop_in;
      iss_k_ff    <= iss_k_in;
      rd_k_ff     <= rd_k_in;
      rd_live_ff  <= rd_live_in;
      status_ff   <= status_in;
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (mem_re) mem_q_ff <= mem[mem_raddr];
   end

   assign req_stall = (state_ff != psev_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// File: tb/tb_postfix_stack_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator_unit
// Feeds decoded postfix tokens through the valid/stall request channel and
// checks every result against a behavioural stack model kept in the bench.
// Directed tokens cover the corner cases. Random programs follow: mostly
// well-formed expressions closed by finish, with noise, divide-by-zero runs
// and deep stacks that overflow. Both sides idle at random, and there is one
// long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_postfix_stack_evaluator_unit;
   import psev_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 80;

   localparam logic [OP_W-1:0]   OP_UNDEFINED = 4'd12;
   localparam logic signed [31:0] INT_MIN     = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX     = 32'sh7fff_ffff;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   postfix_stack_evaluator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // token programme and predicted answers
   req_type token_q[$];
   rsp_type answer_q[$];
   int      mismatch_count = 0;
   int      cycle_count    = 0;

   // model of the stack
   logic signed [DATA_W-1:0] model_stack [STACK_DEPTH];
   int                       model_depth = 0;
   bit                       model_err   = 1'b0;

   function automatic logic signed [DATA_W-1:0] pop_value();
      if (model_depth == 0) return '0;
      model_depth--;
      return model_stack[model_depth];
   endfunction

   function automatic bit push_value(input logic signed [DATA_W-1:0] v);
      if (model_depth >= STACK_DEPTH) return 1'b0;
      model_stack[model_depth] = v;
      model_depth++;
      return 1'b1;
   endfunction

   function automatic logic signed [DATA_W-1:0] peek_value();
      if (model_depth == 0) return '0;
      return model_stack[model_depth-1];
   endfunction

   function automatic rsp_type evaluate_token(input req_type tok);
      rsp_type                  res;
      logic signed [DATA_W-1:0] x, y, c, acc;
      logic [STATUS_W-1:0]      st;
      bit                       fin;
      int                       n;
      res = '0;
      st  = ST_OK;
      fin = 1'b0;
      if (tok.op == OP_FINISH) begin
         fin = 1'b1;
         if (model_err) begin
            st = ST_DIV_ZERO;
            res.top_value = '0;
         end else begin
            res.top_value = peek_value();
         end
         model_depth = 0;
         model_err   = 1'b0;
      end else if (model_err) begin
         st = ST_IGNORED;
      end else begin
         case (tok.op)
            OP_PUSH: begin
               if (!push_value(tok.number)) st = ST_OVERFLOW;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               x = pop_value();
               y = pop_value();
               if (tok.op == OP_ADD) void'(push_value(y + x));
               else if (tok.op == OP_SUB) void'(push_value(y - x));
               else if (tok.op == OP_MUL) void'(push_value(y * x));
               else if (x == 0) begin
                  model_err = 1'b1;
                  st = ST_DIV_ZERO;
               end else if (y == INT_MIN && x == -1) begin
                  void'(push_value(INT_MIN));
               end else begin
                  void'(push_value(y / x));
               end
            end
            OP_NEG: begin
               x = pop_value();
               void'(push_value(-x));
            end
            OP_IF: begin
               x = pop_value();
               y = pop_value();
               c = pop_value();
               void'(push_value((c > 0) ? y : x));
            end
            OP_MIN, OP_MAX: begin
               n   = (tok.fold_count == 0) ? 1 : int'(tok.fold_count);
               acc = pop_value();
               for (int i = 1; i < n; i++) begin
                  x = pop_value();
                  if (tok.op == OP_MIN ? (x < acc) : (acc < x)) acc = x;
               end
               void'(push_value(acc));
            end
            default: ;
         endcase
      end
      if (!fin) res.top_value = peek_value();
      res.entry_count = COUNT_W'(model_depth);
      res.status      = st;
      res.finished    = fin;
      return res;
   endfunction

   // ---------------- programme building ----------------
   task automatic add_token(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] num,
                            input int cnt);
      req_type t;
      t.op         = op;
      t.number     = num;
      t.fold_count = COUNT_W'(cnt);
      token_q.push_back(t);
   endtask

   function automatic logic [DATA_W-1:0] rand_number();
      case ($urandom_range(0, 5))
         0, 1: return DATA_W'($signed($urandom_range(0, 20)) - 10);
         2: begin
            case ($urandom_range(0, 4))
               0: return INT_MIN;
               1: return INT_MAX;
               2: return '1;
               3: return '0;
               default: return 32'd1;
            endcase
         end
         3: return DATA_W'($urandom_range(0, 2000)) - 32'd1000;
         default: return $urandom;
      endcase
   endfunction

   task automatic gen_expression();
      int depth, steps, n;
      logic [OP_W-1:0] op;
      depth = 0;
      steps = $urandom_range(1, 14);
      for (int i = 0; i < steps; i++) begin
         if ((depth < 2 && $urandom_range(0, 7) != 0) || $urandom_range(0, 2) == 0) begin
            add_token(OP_PUSH, rand_number(), $urandom_range(0, 64));
            if (depth < STACK_DEPTH) depth++;
         end else begin
            case ($urandom_range(0, 7))
               0: op = OP_ADD;
               1: op = OP_SUB;
               2: op = OP_MUL;
               3: op = OP_DIV;
               4: op = OP_NEG;
               5: op = OP_IF;
               6: op = OP_MIN;
               default: op = OP_MAX;
            endcase
            n = $urandom_range(0, depth + 1);
            add_token(op, $urandom, n);
            case (op)
               OP_NEG: if (depth == 0) depth = 1;
               OP_IF: depth = (depth > 3) ? depth - 2 : 1;
               OP_MIN, OP_MAX: begin
                  if (n == 0) n = 1;
                  depth = (depth > n) ? depth - n + 1 : 1;
               end
               default: depth = (depth > 2) ? depth - 1 : 1;
            endcase
         end
      end
      if ($urandom_range(0, 9) != 0) add_token(OP_FINISH, $urandom, $urandom_range(0, 64));
   endtask

   task automatic gen_deep_stack();
      int n;
      n = $urandom_range(60, 67);
      for (int i = 0; i < n; i++) add_token(OP_PUSH, rand_number(), 0);
      add_token($urandom_range(0, 1) ? OP_MAX : OP_MIN, $urandom,
                $urandom_range(0, 1) ? 64 : $urandom_range(48, 64));
      add_token(OP_PUSH, rand_number(), 0);
      add_token(OP_FINISH, $urandom, 0);
   endtask

   task automatic gen_div_zero();
      int n;
      add_token(OP_PUSH, rand_number(), 0);
      add_token(OP_PUSH, '0, 0);
      add_token(OP_DIV, $urandom, 0);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++)
         add_token(OP_W'($urandom_range(0, 8)), $urandom, $urandom_range(0, 64));
      add_token(OP_FINISH, $urandom, 0);
   endtask

   task automatic gen_noise();
      int n;
      n = $urandom_range(3, 10);
      for (int i = 0; i < n; i++)
         add_token(OP_W'($urandom_range(0, 15)), rand_number(), $urandom_range(0, 64));
   endtask

   task automatic build_directed();
      add_token(OP_FINISH, '0, 0);          // finish on an empty stack
      add_token(OP_ADD, '0, 0);             // pops from an empty stack
      add_token(OP_FINISH, '0, 0);
      add_token(OP_PUSH, INT_MAX, 0);
      add_token(OP_PUSH, 32'd1, 0);
      add_token(OP_ADD, '0, 0);             // wraps to the most negative value
      add_token(OP_PUSH, '1, 0);
      add_token(OP_DIV, '0, 0);             // quotient overflow
      add_token(OP_NEG, '0, 0);
      add_token(OP_PUSH, 32'd7, 0);
      add_token(OP_PUSH, -32'sd3, 0);
      add_token(OP_SUB, '0, 0);
      add_token(OP_MUL, '0, 0);
      add_token(OP_PUSH, -32'sd7, 0);
      add_token(OP_PUSH, 32'd2, 0);
      add_token(OP_DIV, '0, 0);             // truncates toward zero
      add_token(OP_PUSH, 32'd5, 0);
      add_token(OP_IF, '0, 0);              // condition zero picks false
      add_token(OP_PUSH, 32'd9, 0);
      add_token(OP_PUSH, 32'd1, 0);
      add_token(OP_IF, '0, 0);              // positive condition picks true
      add_token(OP_PUSH, -32'sd4, 0);
      add_token(OP_MIN, '1, 3);             // one missing entry folds in as zero
      add_token(OP_MAX, '1, 0);
      add_token(OP_PUSH, 32'd3, 0);
      add_token(OP_PUSH, '0, 0);
      add_token(OP_DIV, '0, 0);             // divide by zero latches the error
      add_token(OP_PUSH, 32'd1, 0);
      add_token(OP_FINISH, '0, 0);
      add_token(OP_UNDEFINED, '1, 64);
      add_token(OP_MAX, '0, 64);
      add_token(OP_FINISH, '0, 0);
   endtask

   // ---------------- idling ----------------
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;

   function int sender_gap();
      if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
      return send_burst ? 0 : $urandom_range(0, 16);
   endfunction

   function int receiver_gap();
      if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      return recv_burst ? 0 : $urandom_range(0, 16);
   endfunction

   // ---------------- request driver ----------------
   int      send_wait = 0;
   bit      offer;
   bit      take;
   req_type next_tok;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = sender_gap();
      end else begin
         offer = req_valid;
         take  = 1'b0;
         if (req_valid && !req_stall) begin
            answer_q.push_back(evaluate_token(req_data));
            offer = 1'b0;
            send_wait = sender_gap();
         end
         if (!offer) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (token_q.size() > 0) begin
               next_tok = token_q.pop_front();
               offer = 1'b1;
               take  = 1'b1;
            end
         end
         req_valid <= offer;
         if (take) req_data <= next_tok;
      end
   end

   // ---------------- result monitor ----------------
   int      recv_wait    = 0;
   int      results_seen = 0;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (answer_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result top=%0d count=%0d status=%0d fin=%0b",
                        $time, rsp_data.top_value, rsp_data.entry_count,
                        rsp_data.status, rsp_data.finished);
            end else begin
               want = answer_q.pop_front();
               if (rsp_data.top_value !== want.top_value) begin
                  mismatch_count++;
                  $display("%0t: top_value expected %0d got %0d",
                           $time, want.top_value, rsp_data.top_value);
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  mismatch_count++;
                  $display("%0t: entry_count expected %0d got %0d",
                           $time, want.entry_count, rsp_data.entry_count);
               end
               if (rsp_data.status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.finished !== want.finished) begin
                  mismatch_count++;
                  $display("%0t: finished expected %0b got %0b",
                           $time, want.finished, rsp_data.finished);
               end
            end
            // one long hold-off so the request side backs up
            recv_wait = (results_seen == HOLD_AT) ? HOLD_CYCLES : receiver_gap();
         end else if (recv_wait > 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait > 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_postfix_stack_evaluator_unit: FAIL");
         $finish;
      end
   end

   // ---------------- sequencing ----------------
   initial begin
      int pick;
      build_directed();
      while (token_q.size() < RANDOM_ITEMS + 32) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) gen_deep_stack();
         else if (pick < 12) gen_noise();
         else if (pick < 22) gen_div_zero();
         else gen_expression();
      end
      add_token(OP_FINISH, '0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (token_q.size() != 0 || req_valid || answer_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && answer_q.size() == 0)
         $display("tb_postfix_stack_evaluator_unit: PASS");
      else
         $display("tb_postfix_stack_evaluator_unit: FAIL");
      $finish;
   end

endmodule
